// File: design/linear_probe_hash_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear probing hash table unit
// Concurrent checks on clk with synchronous active-low reset rst_n.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked only out of reset.
`define LPHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked only out of reset.
`define LPHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LPHT_ASSERT_IMP(lbl, ante, cons, msg)
`define LPHT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: design/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared field widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int CMD_BITS         = 2;
  localparam int KEY_FIELD_BITS   = 16;
  localparam int VALUE_FIELD_BITS = 64;
  localparam int STATUS_BITS      = 2;
  localparam int SLOT_FIELD_BITS  = 5;
  localparam int IN_DATA_BITS     = 88;
  localparam int OUT_DATA_BITS    = 72;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_GONE  = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic load;
    logic hash_run;
    logic probe_start;
    logic probe_run;
    logic emit;
  } lpht_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic hash_done;
    logic op_valid;
    logic probe_end;
  } lpht_sts_t;

endpackage

// File: design/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl
// Controller state machine: clearing pass, accept, hash, probe, result.
// ----------------------------------------------------------------------------
module lpht_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  lpht_pkg::lpht_sts_t sts,
  output lpht_pkg::lpht_ctl_t ctl
);

  import lpht_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ctl.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        ctl.hash_run = 1'b1;
        if (sts.hash_done) begin
          if (sts.op_valid) begin
            ctl.probe_start = 1'b1;
            state_nxt       = S_PROBE;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_PROBE: begin
        ctl.probe_run = 1'b1;
        if (sts.probe_end) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// File: design/lpht_dp.sv
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: operand registers, home slot hash, probe pointers, slot RAM,
// result and output registers.
// ----------------------------------------------------------------------------
module lpht_dp #(
  parameter int TABLE_SLOTS  = 32,
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lpht_pkg::lpht_ctl_t                    ctl,
  output lpht_pkg::lpht_sts_t                    sts,
  input  logic [lpht_pkg::CMD_BITS-1:0]          in_cmd,
  input  logic [lpht_pkg::KEY_FIELD_BITS-1:0]    in_key,
  input  logic [lpht_pkg::VALUE_FIELD_BITS-1:0]  in_value,
  output lpht_pkg::status_t                      out_status,
  output logic [lpht_pkg::SLOT_FIELD_BITS-1:0]   out_slot,
  output logic [lpht_pkg::VALUE_FIELD_BITS-1:0]  out_value
);

  import lpht_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam int WORD_W = 2 + KEY_BITS + PAYLOAD_BITS;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0]  ALL_CNT   = CNT_W'(TABLE_SLOTS);
  localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(TABLE_SLOTS - 1);

  // Operand registers.
  logic [CMD_BITS-1:0]     op_r;
  logic [KEY_BITS-1:0]     key_r;
  logic [PAYLOAD_BITS-1:0] val_r;

  // Probe control.
  logic [SLOT_W-1:0] iss_r, chk_r, clr_r;
  logic [CNT_W-1:0]  iss_cnt_r, chk_cnt_r;
  logic              rvld_r;
  logic [SLOT_W-1:0] home;

  // Result and output registers.
  status_t                 res_status_r, out_status_r;
  logic [SLOT_W-1:0]       res_slot_r, out_slot_r;
  logic [PAYLOAD_BITS-1:0] res_val_r, out_val_r;

  // RAM ports.
  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  mark_t                   rd_mark;
  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic                    key_hit, is_last, issuing;
  logic                    end_hit, end_miss, end_free, end_full;

  // ---------------------------------------------------------------------------
  // Home slot: key modulo TABLE_SLOTS.
  // ---------------------------------------------------------------------------
  if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0) begin : g_mask
    assign home          = SLOT_W'(key_r);
    assign sts.hash_done = 1'b1;
  end else begin : g_recip
    // Reciprocal multiplication, product then remainder registered. The quotient
    // (key * RECIP) >> RSHIFT is exact for every KEY_BITS-bit key, and the
    // remainder fits in SLOT_W bits, so only the low bits of key - q * N count.
    localparam int RSHIFT = KEY_BITS + SLOT_W;
    localparam int PROD_W = 2 * KEY_BITS + 2;
    localparam longint unsigned RECIP_VAL =
      ((64'd1 << RSHIFT) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
    localparam logic [KEY_BITS+1:0] RECIP   = (KEY_BITS + 2)'(RECIP_VAL);
    localparam logic [SLOT_W-1:0]   SLOTS_C = SLOT_W'(TABLE_SLOTS);
    logic [PROD_W-1:0] prod_r;
    logic [SLOT_W-1:0] rem_r, rem_nxt, quot_lo;
    logic [1:0]        hstep_r;
    logic              done;

    assign quot_lo = SLOT_W'(prod_r >> RSHIFT);
    assign rem_nxt = SLOT_W'(key_r) - SLOT_W'(quot_lo * SLOTS_C);
    assign done    = (hstep_r == 2'd2);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hstep_r <= '0;
      end else if (ctl.load) begin
        hstep_r <= '0;
      end else if (ctl.hash_run && !done) begin
        hstep_r <= hstep_r + 2'd1;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.hash_run && (hstep_r == 2'd0)) begin
        prod_r <= PROD_W'(key_r) * PROD_W'(RECIP);
      end
      if (ctl.hash_run && (hstep_r == 2'd1)) begin
        rem_r <= rem_nxt;
      end
    end

    assign home          = rem_r;
    assign sts.hash_done = done;
  end

  // ---------------------------------------------------------------------------
  // Operand capture.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r  <= in_cmd;
      key_r <= KEY_BITS'(in_key);
      val_r <= PAYLOAD_BITS'(in_value);
    end
  end

  assign sts.op_valid = (op_r == OP_SEARCH) || (op_r == OP_INSERT) || (op_r == OP_DELETE);

  // ---------------------------------------------------------------------------
  // Probe: a read is issued each cycle, its data is checked the next one.
  // ---------------------------------------------------------------------------
  assign issuing = ctl.probe_run && (iss_cnt_r != ALL_CNT);
  assign rd_mark = mark_t'(ram_rdata[1:0]);
  assign rd_key  = ram_rdata[KEY_BITS+1:2];
  assign rd_pay  = ram_rdata[WORD_W-1:KEY_BITS+2];
  assign key_hit = (rd_mark == MARK_USED) && (rd_key == key_r);
  assign is_last = (chk_cnt_r == LAST_CNT);

  always_comb begin
    end_hit  = 1'b0;
    end_miss = 1'b0;
    end_free = 1'b0;
    end_full = 1'b0;
    case (op_t'(op_r))
      OP_INSERT: begin
        end_free = rvld_r && (rd_mark != MARK_USED);
        end_full = rvld_r && (rd_mark == MARK_USED) && is_last;
      end
      OP_SEARCH, OP_DELETE: begin
        end_hit  = rvld_r && key_hit;
        end_miss = rvld_r && !key_hit && ((rd_mark == MARK_EMPTY) || is_last);
      end
      default: begin
      end
    endcase
  end

  assign sts.probe_end  = end_hit || end_miss || end_free || end_full;
  assign sts.clear_last = (clr_r == LAST_SLOT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= '0;
      rvld_r    <= 1'b0;
      iss_cnt_r <= '0;
      chk_cnt_r <= '0;
    end else begin
      if (ctl.clear_step) begin
        clr_r <= clr_r + SLOT_W'(1);
      end
      if (ctl.probe_start) begin
        rvld_r    <= 1'b0;
        iss_cnt_r <= '0;
        chk_cnt_r <= '0;
      end else if (ctl.probe_run) begin
        rvld_r <= issuing;
        if (issuing) begin
          iss_cnt_r <= iss_cnt_r + CNT_W'(1);
        end
        if (rvld_r) begin
          chk_cnt_r <= chk_cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.probe_start) begin
      iss_r <= home;
    end else if (issuing) begin
      iss_r <= (iss_r == LAST_SLOT) ? '0 : iss_r + SLOT_W'(1);
      chk_r <= iss_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Slot store: mark, key and payload in one word.
  // ---------------------------------------------------------------------------
  assign ram_re    = issuing;
  assign ram_we    = ctl.clear_step ||
                     (ctl.probe_run && (end_free || (end_hit && (op_t'(op_r) == OP_DELETE))));
  assign ram_waddr = ctl.clear_step ? clr_r : chk_r;

  always_comb begin
    if (ctl.clear_step) begin
      ram_wdata = {{PAYLOAD_BITS{1'b0}}, {KEY_BITS{1'b0}}, MARK_EMPTY};
    end else if (end_free) begin
      ram_wdata = {val_r, key_r, MARK_USED};
    end else begin
      ram_wdata = {rd_pay, rd_key, MARK_GONE};
    end
  end

  lpht_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(iss_r),
    .rdata(ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Result and output registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      res_status_r <= ST_MISS;
      res_slot_r   <= '0;
      res_val_r    <= '0;
    end else if (ctl.probe_run) begin
      if (end_hit) begin
        res_status_r <= ST_DONE;
        res_slot_r   <= chk_r;
        res_val_r    <= rd_pay;
      end else if (end_free) begin
        res_status_r <= ST_DONE;
        res_slot_r   <= chk_r;
      end else if (end_full) begin
        res_status_r <= ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_val_r    <= res_val_r;
    end
  end

  assign out_status = out_status_r;
  assign out_slot   = SLOT_FIELD_BITS'(out_slot_r);
  assign out_value  = VALUE_FIELD_BITS'(out_val_r);

endmodule

// File: design/linear_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing hash table with linear probing and tombstone deletes.
//
// One transaction on the in_ channel carries a command (search, insert or
// delete), a key and a payload word. Exactly one transaction follows on the
// out_ channel with a status, the slot index and the payload found or removed.
// The home slot is the key modulo TABLE_SLOTS; the probe walks forward one
// slot per cycle, wrapping, over at most TABLE_SLOTS slots.
// From acceptance to out_tvalid the item passes hash, probe and hand-off to
// the output register; the hash adds a reciprocal multiplication when
// TABLE_SLOTS is not a power of two. The next transaction is accepted only
// after the previous result has been handed to the output register. The
// single read port of the slot RAM sets the probe rate of one slot per cycle;
// one item is in work at a time.
// After reset the block clears every slot mark, one slot a cycle, with
// in_tready low. The result sits in an output register, so a stalled
// receiver does not stop the next transaction from being accepted; only its
// result waits until the register frees up.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_unit_macros.svh"

module linear_probe_hash_table_unit #(
  parameter int TABLE_SLOTS  = 32,
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata: cmd[1:0], key[17:2], entry_value[81:18], zero pad[87:82]
  input  logic [lpht_pkg::IN_DATA_BITS-1:0]   in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata: status[1:0], slot_index[6:2], value_out[70:7], zero pad[71]
  output logic [lpht_pkg::OUT_DATA_BITS-1:0]  out_tdata
);

  import lpht_pkg::*;

  lpht_ctl_t                    ctl;
  lpht_sts_t                    sts;
  status_t                      res_status;
  logic [SLOT_FIELD_BITS-1:0]   res_slot;
  logic [VALUE_FIELD_BITS-1:0]  res_value;

  // Sequencing: clearing pass, accept, hash, probe and hand-off to output.
  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Operands, probe pointers, slot store and result registers.
  lpht_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BITS    (KEY_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_cmd    (in_tdata[1:0]),
    .in_key    (in_tdata[17:2]),
    .in_value  (in_tdata[81:18]),
    .out_status(res_status),
    .out_slot  (res_slot),
    .out_value (res_value)
  );

  assign out_tdata = {1'b0, res_value, res_slot, res_status};

  // No transaction may be taken while slot marks are still being cleared.
  `LPHT_ASSERT_IMP(a_no_accept_in_clear, ctl.clear_step, !in_tready, "accept during clear")

  // Only one item is in work: acceptance drops in_tready in the next cycle.
  `LPHT_ASSERT_NXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "second item taken")

  // Any result other than done carries a zero slot index and zero payload.
  `LPHT_ASSERT_IMP(a_fail_is_zero, out_tvalid && (out_tdata[1:0] != ST_DONE), (out_tdata[70:2] == '0), "nonzero fields on failed result")

endmodule
